// ----- hw/rtl/apss_pkg.sv -----
// Package for the ADC pair-average voltmeter with seven-segment scan.
// Holds the item and result structs, scan codes and the digit pattern table.
// Has no dependencies; every module of the block uses it.
`default_nettype none

package apss_pkg;

	// One input item.
	typedef struct packed {
		logic       action;
		logic [9:0] sample;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] seg_lines;
		logic [6:0] anode_lines;
		logic [7:0] pwm_duty;
		logic       average_done;
	} result_t;

	// Values held by the averager and shown by the scan.
	typedef struct packed {
		logic [8:0] main_value;
		logic [8:0] second_value;
	} view_t;

	// Action codes.
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// Scan positions.
	typedef enum logic [2:0] {
		POS_MAIN_HUND = 3'd0,
		POS_MAIN_TENS = 3'd1,
		POS_MAIN_ONES = 3'd2,
		POS_SEC_HUND  = 3'd3,
		POS_SEC_TENS  = 3'd4,
		POS_BLANK     = 3'd5
	} scan_pos_t;

	localparam logic [7:0] SEG_DP    = 8'h80;
	localparam logic [7:0] SEG_BLANK = 8'hFF;

	// Fixed-point reciprocals: floor(x/10) for x up to 2046, and for the shown
	// value floor(v/10) and floor(v/100) for v up to 510.
	localparam logic [12:0] RECIP_TEN_SUM  = 13'd6554;  // 2^16 / 10, rounded up
	localparam logic [7:0]  RECIP_TEN_VAL  = 8'd205;    // 2^11 / 10, rounded up
	localparam logic [5:0]  RECIP_HUND_VAL = 6'd41;     // 2^12 / 100, rounded up

	// Active-high segment pattern a..g for one decimal digit.
	function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
		logic [7:0] p;
		unique case (digit)
			4'd0: p = 8'h3F;
			4'd1: p = 8'h06;
			4'd2: p = 8'h5B;
			4'd3: p = 8'h4F;
			4'd4: p = 8'h66;
			4'd5: p = 8'h6D;
			4'd6: p = 8'h7D;
			4'd7: p = 8'h07;
			4'd8: p = 8'h7F;
			4'd9: p = 8'h6F;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/apss_avg.sv -----
// Pair averager: sums samples in pairs and forms the duty and shown values.
// Depends on apss_pkg for the item and view types.
`default_nettype none

module apss_avg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire apss_pkg::item_t item,
	output apss_pkg::view_t      view,
	output logic [7:0]           duty_next,
	output logic                 done_next
);

	logic [10:0] sample_sum_q;
	logic        pair_half_q;
	logic [7:0]  duty_value_q;
	logic [8:0]  main_value_q;
	logic [8:0]  second_value_q;

	logic [10:0] sum_add;
	logic [23:0] recip_prod;
	logic [7:0]  avg;
	logic [9:0]  avg_x5;
	logic [8:0]  shown;
	logic        is_sample;

	always_comb begin
		sum_add    = sample_sum_q + {1'b0, item.sample};
		recip_prod = 24'(sum_add) * 24'(apss_pkg::RECIP_TEN_SUM);
		avg        = recip_prod[23:16];
		avg_x5     = {avg, 2'b00} + {2'b00, avg};
		shown      = avg_x5[9:1];
		is_sample  = en && (item.action == apss_pkg::ACT_SAMPLE);
		done_next  = is_sample && pair_half_q;
		duty_next  = done_next ? avg : duty_value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_sum_q   <= '0;
			pair_half_q    <= 1'b0;
			duty_value_q   <= '0;
			main_value_q   <= '0;
			second_value_q <= '0;
		end else if (is_sample) begin
			if (pair_half_q) begin
				duty_value_q   <= avg;
				main_value_q   <= shown;
				second_value_q <= shown;
				sample_sum_q   <= '0;
				pair_half_q    <= 1'b0;
			end else begin
				sample_sum_q <= sum_add;
				pair_half_q  <= 1'b1;
			end
		end
	end

	assign view.main_value   = main_value_q;
	assign view.second_value = second_value_q;

endmodule

`default_nettype wire

// ----- hw/rtl/apss_scan.sv -----
// Display scan: picks a digit for the current position and latches segments
// and anode. Depends on apss_pkg for the view type, scan codes and patterns.
`default_nettype none

module apss_scan (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire apss_pkg::item_t item,
	input  wire apss_pkg::view_t view,
	output logic [7:0]           seg_next,
	output logic [6:0]           anode_next
);

	apss_pkg::scan_pos_t pos_q;
	apss_pkg::scan_pos_t pos_next;
	logic [7:0]          seg_drive_q;
	logic [6:0]          anode_drive_q;

	logic        is_tick;
	logic [8:0]  value;
	logic [16:0] prod_ten;
	logic [14:0] prod_hund;
	logic [5:0]  q_ten;
	logic [2:0]  q_hund;
	logic [8:0]  ones_wide;
	logic [5:0]  tens_wide;
	logic [3:0]  digit;
	logic        dp;
	logic [7:0]  seg;
	logic [6:0]  anode;

	always_comb begin
		is_tick = en && (item.action == apss_pkg::ACT_TICK);
		value   = (pos_q == apss_pkg::POS_MAIN_HUND || pos_q == apss_pkg::POS_MAIN_TENS ||
			pos_q == apss_pkg::POS_MAIN_ONES) ? view.main_value : view.second_value;

		prod_ten  = 17'(value) * 17'(apss_pkg::RECIP_TEN_VAL);
		prod_hund = 15'(value) * 15'(apss_pkg::RECIP_HUND_VAL);
		q_ten     = prod_ten[16:11];
		q_hund    = prod_hund[14:12];
		ones_wide = value - 9'(q_ten) * 9'd10;
		tens_wide = q_ten - 6'(q_hund * 3'd5 * 2);

		digit    = 4'd0;
		dp       = 1'b0;
		seg      = apss_pkg::SEG_BLANK;
		anode    = 7'd0;
		pos_next = apss_pkg::POS_MAIN_HUND;
		unique case (pos_q)
			apss_pkg::POS_MAIN_HUND, apss_pkg::POS_SEC_HUND: begin
				digit = {1'b0, q_hund};
				dp    = 1'b1;
			end
			apss_pkg::POS_MAIN_TENS, apss_pkg::POS_SEC_TENS: begin
				digit = tens_wide[3:0];
			end
			apss_pkg::POS_MAIN_ONES: begin
				digit = ones_wide[3:0];
			end
			default: begin
				digit = 4'd0;
			end
		endcase

		unique case (pos_q)
			apss_pkg::POS_MAIN_HUND, apss_pkg::POS_MAIN_TENS, apss_pkg::POS_MAIN_ONES,
			apss_pkg::POS_SEC_HUND, apss_pkg::POS_SEC_TENS: begin
				seg      = ~(apss_pkg::digit_pattern(digit) | (dp ? apss_pkg::SEG_DP : 8'h00));
				anode    = 7'(8'd2 << pos_q);
				pos_next = apss_pkg::scan_pos_t'(pos_q + 3'd1);
			end
			apss_pkg::POS_BLANK: begin
				seg      = apss_pkg::SEG_BLANK;
				anode    = 7'(8'd2 << pos_q);
				pos_next = apss_pkg::POS_MAIN_HUND;
			end
			default: begin
				seg      = apss_pkg::SEG_BLANK;
				anode    = 7'd0;
				pos_next = apss_pkg::POS_MAIN_HUND;
			end
		endcase

		seg_next   = is_tick ? seg : seg_drive_q;
		anode_next = is_tick ? anode : anode_drive_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= apss_pkg::POS_MAIN_HUND;
			seg_drive_q   <= '0;
			anode_drive_q <= '0;
		end else if (is_tick) begin
			pos_q         <= pos_next;
			seg_drive_q   <= seg;
			anode_drive_q <= anode;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/adc_pair_average_seven_segment_scan.sv -----
// Top level of the ADC pair-average voltmeter with six-position display scan.
// Depends on apss_pkg, apss_avg and apss_scan.
//
//   Channel   Direction  Handshake                  Payload
//   item      in         item_valid / item_stall    apss_pkg::item_t (action, sample)
//   result    out        result_valid / result_stall apss_pkg::result_t
//
// Every accepted item yields exactly one result, after passing through the input
// register and then the result register. A new item can be accepted in every
// cycle while the result channel is not stalled; the single averaging multiply
// and the digit extraction multiplies sit between the two registers.
// Reset clears the pair sum, shown values, duty, scan position and the latched
// segment and anode drive to zero, and empties both pipeline registers.
// A stalled result holds the result register and, through it, the input
// register; item_stall rises only when the input register holds a transfer
// that cannot move on.
`default_nettype none

module adc_pair_average_seven_segment_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire apss_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output apss_pkg::result_t      result
);

	// Input register stage.
	logic              valid_s1;
	apss_pkg::item_t   item_s1;

	// Result register stage.
	logic              valid_s2;
	apss_pkg::result_t result_s2;

	logic              s2_free;
	logic              advance;
	logic              accept;

	apss_pkg::view_t   view;
	logic [7:0]        duty_next;
	logic              done_next;
	logic [7:0]        seg_next;
	logic [6:0]        anode_next;

	// The result register can take a new transfer when it is empty or its
	// content is being taken in this cycle.
	assign s2_free    = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && s2_free;
	assign item_stall = valid_s1 && !s2_free;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// The averager and the scan both update their state as the item in the
	// input register moves into the result register, and report the values
	// that hold after that update.
	apss_avg u_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.item      (item_s1),
		.view      (view),
		.duty_next (duty_next),
		.done_next (done_next)
	);

	apss_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.item       (item_s1),
		.view       (view),
		.seg_next   (seg_next),
		.anode_next (anode_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.seg_lines    <= seg_next;
			result_s2.anode_lines  <= anode_next;
			result_s2.pwm_duty     <= duty_next;
			result_s2.average_done <= done_next;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// The pair average can never exceed 204.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.pwm_duty <= 8'd204))
		else $error("pwm duty beyond the largest pair average");

	// At most one anode is driven.
	a_anode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0(result.anode_lines))
		else $error("more than one anode driven");

	// A scan tick never reports a completed pair.
	a_tick_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.action == apss_pkg::ACT_TICK)) |=> !result.average_done)
		else $error("scan tick flagged as a completed pair");

	// The input register is only held back when it holds a transfer.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && result_stall))
		else $error("input stalled without a blocked transfer");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for adc_pair_average_seven_segment_scan: random and directed samples and scan ticks.
// Depends on apss_pkg and the RTL top level only. A behavioural model of the meter inside the
// bench predicts every reading, and each reading is compared field by field.
`timescale 1ns / 1ps

module tb;

	// Cycles without any transfer on either channel before the run is abandoned. This is well
	// above the longest receiver stall plus the longest sender gap and the pipeline depth.
	localparam int STALL_LIMIT = 2000;
	// Two pipeline registers, so a few cycles of quiet at the end are ample.
	localparam int SETTLE_CYCLES = 8;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	apss_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	apss_pkg::result_t result;

	// Behavioural copy of the meter state.
	logic [10:0]         pair_sum;
	logic                pair_half;
	logic [8:0]          main_val;
	logic [8:0]          second_val;
	logic [7:0]          duty_val;
	apss_pkg::scan_pos_t scan_pos;
	logic [7:0]          seg_latch;
	logic [6:0]          anode_latch;

	// Readings predicted but not yet seen on the result channel, oldest first.
	apss_pkg::result_t pending_readings[$];

	int error_count = 0;
	int reading_count = 0;
	int transfer_count = 0;
	int tick_count = 0;
	int pair_count = 0;
	int idle_cycles = 0;
	int stall_cycle = 0;
	int burst_left = 0;
	bit pacing = 1'b0;

	adc_pair_average_seven_segment_scan u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #2 clk = ~clk;

	// Active-high segments a..g for one decimal digit.
	function automatic logic [7:0] segments_for_digit(input int digit);
		logic [7:0] p;
		case (digit)
			0: p = 8'h3F;
			1: p = 8'h06;
			2: p = 8'h5B;
			3: p = 8'h4F;
			4: p = 8'h66;
			5: p = 8'h6D;
			6: p = 8'h7D;
			7: p = 8'h07;
			8: p = 8'h7F;
			default: p = 8'h6F;
		endcase
		return p;
	endfunction

	// Active-low drive for the digit of a shown value at a given decimal place.
	function automatic logic [7:0] digit_drive(input logic [8:0] value, input int place,
			input logic point);
		logic [7:0] p;
		p = segments_for_digit((int'(value) / place) % 10);
		if (point) begin
			p = p | apss_pkg::SEG_DP;
		end
		return ~p;
	endfunction

	function automatic void meter_reset();
		pair_sum = '0;
		pair_half = 1'b0;
		main_val = '0;
		second_val = '0;
		duty_val = '0;
		scan_pos = apss_pkg::POS_MAIN_HUND;
		seg_latch = '0;
		anode_latch = '0;
	endfunction

	// Advances the meter by one accepted item and queues the reading it produces.
	function automatic void meter_step(input apss_pkg::item_t it);
		apss_pkg::result_t want;
		int shown;
		want = '0;
		if (it.action == apss_pkg::ACT_SAMPLE) begin
			pair_sum = pair_sum + 11'(it.sample);
			if (pair_half) begin
				duty_val = 8'(int'(pair_sum) / 10);
				shown = (int'(duty_val) * 5) / 2;
				main_val = 9'(shown);
				second_val = 9'(shown);
				pair_sum = '0;
				pair_half = 1'b0;
				want.average_done = 1'b1;
				pair_count++;
			end else begin
				pair_half = 1'b1;
			end
		end else begin
			anode_latch = 7'b1 << (int'(scan_pos) + 1);
			case (scan_pos)
				apss_pkg::POS_MAIN_HUND: seg_latch = digit_drive(main_val, 100, 1'b1);
				apss_pkg::POS_MAIN_TENS: seg_latch = digit_drive(main_val, 10, 1'b0);
				apss_pkg::POS_MAIN_ONES: seg_latch = digit_drive(main_val, 1, 1'b0);
				apss_pkg::POS_SEC_HUND:  seg_latch = digit_drive(second_val, 100, 1'b1);
				apss_pkg::POS_SEC_TENS:  seg_latch = digit_drive(second_val, 10, 1'b0);
				default:                 seg_latch = apss_pkg::SEG_BLANK;
			endcase
			scan_pos = (scan_pos == apss_pkg::POS_BLANK) ? apss_pkg::POS_MAIN_HUND :
				apss_pkg::scan_pos_t'(scan_pos + 3'd1);
			tick_count++;
		end
		want.seg_lines = seg_latch;
		want.anode_lines = anode_latch;
		want.pwm_duty = duty_val;
		pending_readings.push_back(want);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_reading(input apss_pkg::result_t got);
		apss_pkg::result_t want;
		if (pending_readings.size() == 0) begin
			report_mismatch($sformatf("reading 0x%0h arrived with nothing pending", got));
		end else begin
			want = pending_readings.pop_front();
			if (got.seg_lines !== want.seg_lines)
				report_mismatch($sformatf("reading %0d seg_lines 0x%0h, expected 0x%0h",
					reading_count, got.seg_lines, want.seg_lines));
			if (got.anode_lines !== want.anode_lines)
				report_mismatch($sformatf("reading %0d anode_lines 0x%0h, expected 0x%0h",
					reading_count, got.anode_lines, want.anode_lines));
			if (got.pwm_duty !== want.pwm_duty)
				report_mismatch($sformatf("reading %0d pwm_duty %0d, expected %0d",
					reading_count, got.pwm_duty, want.pwm_duty));
			if (got.average_done !== want.average_done)
				report_mismatch($sformatf("reading %0d average_done %0b, expected %0b",
					reading_count, got.average_done, want.average_done));
			reading_count++;
		end
	endtask

	// Both channels are sampled at the rising edge, before any of this edge's nonblocking
	// updates land, so a transfer is seen exactly as the design sees it. The prediction is
	// made first; a result can never belong to an item accepted at the same edge anyway.
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			meter_step(item);
			transfer_count++;
		end
		if (arst_n && result_valid && !result_stall) begin
			check_reading(result);
		end
	end

	// Receiver back-pressure. It switches in turn between four behaviours: no stall at all,
	// light random stall, heavy random stall and a regular periodic stall.
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		case ((stall_cycle >> 6) % 4)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 1) == 1);
			default: result_stall <= (stall_cycle % 3 == 0);
		endcase
	end

	// Watchdog: the run is abandoned if neither channel completes a transfer for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("adc_pair_average_seven_segment_scan test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Presents one item and returns at the edge on which it is transferred. The valid is left
	// high, so the next call can follow in the very next cycle without a bubble.
	task automatic send_item(input logic act, input logic [9:0] smp);
		item_valid <= 1'b1;
		item <= {act, smp};
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic hold_off(input int cycles);
		item_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Sends in bursts of random length with random gaps between them while pacing is on.
	task automatic send_paced(input logic act, input logic [9:0] smp);
		if (pacing && burst_left == 0) begin
			hold_off($urandom_range(1, 6));
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		send_item(act, smp);
	endtask

	// Stops sending and waits until every predicted reading has been checked.
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Samples weighted towards the ends of the converter range.
	function automatic logic [9:0] pick_sample();
		int roll;
		roll = $urandom_range(0, 7);
		if (roll == 0) return 10'd0;
		if (roll == 1) return 10'h3FF;
		return 10'($urandom_range(0, 1023));
	endfunction

	function automatic logic [9:0] tick_noise();
		return 10'($urandom_range(0, 1023));
	endfunction

	// Samples arrive before any tick, so segments and anodes must still read their reset value.
	// The pair of full-scale samples gives the largest duty and the largest shown value.
	task automatic test_before_first_tick();
		send_item(apss_pkg::ACT_SAMPLE, 10'h3FF);
		send_item(apss_pkg::ACT_SAMPLE, 10'h3FF);
	endtask

	// Seven ticks walk every display position, including the blank one, and wrap back to the
	// first. The sample field is toggled between its extremes to show that ticks ignore it.
	task automatic test_full_scan_wrap();
		repeat (3) begin
			send_item(apss_pkg::ACT_TICK, 10'h3FF);
			send_item(apss_pkg::ACT_TICK, 10'h000);
		end
		send_item(apss_pkg::ACT_TICK, 10'h2AA);
	endtask

	// A pair of zero samples brings every shown digit back to zero.
	task automatic test_zero_reading();
		send_item(apss_pkg::ACT_SAMPLE, 10'd0);
		send_item(apss_pkg::ACT_SAMPLE, 10'd0);
		repeat (6) send_item(apss_pkg::ACT_TICK, 10'h155);
	endtask

	// Pair sums just below and at the first step of the division by ten.
	task automatic test_division_steps();
		send_item(apss_pkg::ACT_SAMPLE, 10'd1);
		send_item(apss_pkg::ACT_SAMPLE, 10'd8);
		send_item(apss_pkg::ACT_SAMPLE, 10'd5);
		send_item(apss_pkg::ACT_SAMPLE, 10'd5);
		repeat (3) send_item(apss_pkg::ACT_TICK, 10'h3FF);
	endtask

	// Back-to-back transfers from the sender; only the receiver stalls.
	task automatic test_back_to_back(input int n_items);
		pacing = 1'b0;
		repeat (n_items) begin
			if ($urandom_range(0, 2) == 0)
				send_item(apss_pkg::ACT_TICK, tick_noise());
			else
				send_item(apss_pkg::ACT_SAMPLE, pick_sample());
		end
	endtask

	// Short runs of items, each followed by a pause until the pipeline has fully emptied.
	task automatic test_drain_pauses(input int rounds);
		pacing = 1'b1;
		repeat (rounds) begin
			send_paced(apss_pkg::ACT_SAMPLE, pick_sample());
			send_paced(apss_pkg::ACT_SAMPLE, pick_sample());
			repeat (4) send_paced(apss_pkg::ACT_TICK, tick_noise());
			wait_drained();
		end
	endtask

	// Mostly well-formed traffic: a pair of samples followed by part of a scan, so that every
	// position shows many different values. The rest is single items of either kind, and lone
	// samples that shift the pairing.
	task automatic test_random_readings(input int n_items);
		int sent;
		int kind;
		int ticks;
		sent = 0;
		pacing = 1'b1;
		while (sent < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				send_paced(apss_pkg::ACT_SAMPLE, pick_sample());
				send_paced(apss_pkg::ACT_SAMPLE, pick_sample());
				ticks = $urandom_range(0, 8);
				repeat (ticks) send_paced(apss_pkg::ACT_TICK, tick_noise());
				sent += 2 + ticks;
			end else if (kind < 9) begin
				send_paced(logic'($urandom_range(0, 1)), tick_noise());
				sent++;
			end else begin
				send_paced(apss_pkg::ACT_SAMPLE, pick_sample());
				ticks = $urandom_range(1, 6);
				repeat (ticks) send_paced(apss_pkg::ACT_TICK, tick_noise());
				sent += 1 + ticks;
			end
		end
	endtask

	initial begin
		meter_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_first_tick();
		test_full_scan_wrap();
		test_zero_reading();
		test_division_steps();
		test_back_to_back(60);
		test_drain_pauses(6);
		test_random_readings(530);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d item transfers (%0d scan ticks, %0d completed pairs);",
			transfer_count, tick_count, pair_count);
		$display("%0d readings were checked against the model, with %0d mismatches.",
			reading_count, error_count);
		if (error_count == 0) begin
			$display("adc_pair_average_seven_segment_scan test passed");
		end else begin
			$display("adc_pair_average_seven_segment_scan test failed");
		end
		$finish;
	end

endmodule
